FILE: rtl/core/oldest_ready_command_select_unit_assert.svh
// Assertion macros for the oldest ready command select unit.
`ifndef OLDEST_READY_COMMAND_SELECT_UNIT_ASSERT_SVH
`define OLDEST_READY_COMMAND_SELECT_UNIT_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define ORCS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("orcs assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define ORCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("orcs assertion failed");

`endif

FILE: rtl/core/orcs_pkg.sv
// Types and constants shared by the oldest ready command select unit.
`timescale 1ns / 1ps
package orcs_pkg;

	localparam int CodeWidth    = 5;
	localparam int SlotWidth    = 4;
	localparam int PayloadWidth = 32;
	localparam int TimeWidth    = 48;
	localparam int LengthWidth  = 16;
	localparam int KeyWidth     = TimeWidth + 1;

	typedef logic [CodeWidth-1:0]    code_t;
	typedef logic [SlotWidth-1:0]    slot_t;
	typedef logic [PayloadWidth-1:0] payload_t;
	typedef logic [TimeWidth-1:0]    time_t;
	typedef logic [LengthWidth-1:0]  length_t;
	typedef logic [KeyWidth-1:0]     key_t;

	typedef struct packed {
		code_t    code;
		slot_t    slot;
		payload_t payload;
		time_t    issue;
	} record_t;

	localparam time_t NopTime = {TimeWidth{1'b1}};

	typedef enum logic {
		POLICY_OLDEST_ALL = 1'b0,
		POLICY_RAS_CAS    = 1'b1
	} policy_t;

endpackage

FILE: rtl/core/oldest_ready_command_select_unit.sv
// Oldest ready command select unit: running oldest-first winner over a list of ready commands.
// Throughput is one request per cycle, set by the running-winner update (49-bit add and compare),
// except while a last request waits in s1 (in_stall). A last request updates the winners as it
// leaves s1; its result goes to s2, then to the output register. Other requests produce no result.
// arst_n clears all valid flags, both running winners and the select policy (oldest over all).
// There is no clearing pass; requests are accepted in the first cycle after reset.
`timescale 1ns / 1ps
`include "oldest_ready_command_select_unit_assert.svh"
module oldest_ready_command_select_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               entry_valid,
	input  orcs_pkg::code_t    command_code,
	input  logic               is_row_command,
	input  orcs_pkg::length_t  command_length,
	input  orcs_pkg::time_t    issue_time,
	input  orcs_pkg::payload_t payload_id,
	input  orcs_pkg::slot_t    entry_index,
	input  orcs_pkg::time_t    current_time,
	input  logic               last_entry,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               grant,
	output orcs_pkg::code_t    granted_command,
	output orcs_pkg::slot_t    granted_entry,
	output orcs_pkg::payload_t granted_payload,
	output orcs_pkg::time_t    granted_time
);
	import orcs_pkg::*;

	policy_t  policy_q;

	logic     valid_s1;
	logic     entry_valid_s1;
	logic     is_row_s1;
	length_t  length_s1;
	record_t  cand_s1;
	time_t    now_s1;
	logic     last_s1;

	logic     row_found_q;
	key_t     row_key_q;
	record_t  row_rec_q;
	logic     col_found_q;
	key_t     col_key_q;
	record_t  col_rec_q;

	logic     valid_s2;
	logic     policy_s2;
	logic     row_found_s2;
	record_t  row_rec_s2;
	logic     col_found_s2;
	record_t  col_rec_s2;
	time_t    now_s2;

	logic     out_valid_q;
	logic     grant_q;
	record_t  out_rec_q;

	logic     s2_go;
	logic     s2_free;
	logic     s1_go;
	logic     s1_fire;
	logic     in_fire;
	key_t     cand_key;
	logic     to_col;
	logic     row_take;
	logic     col_take;
	logic     row_found_d;
	key_t     row_key_d;
	record_t  row_rec_d;
	logic     col_found_d;
	key_t     col_key_d;
	record_t  col_rec_d;
	logic     have;
	record_t  win;
	logic     grant_d;
	record_t  out_rec_d;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POLICY_OLDEST_ALL;
		end else if (cfg_valid && cfg_ready) begin
			policy_q <= policy_t'(cfg_data);
		end
	end

	// Handshake: an s1 item that is not last never waits on the later stages.
	assign s2_go    = !out_valid_q || !out_stall;
	assign s2_free  = !valid_s2 || s2_go;
	assign s1_go    = !last_s1 || s2_free;
	assign s1_fire  = valid_s1 && s1_go;
	assign in_stall = valid_s1 && !s1_go;
	assign in_fire  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || s1_go) begin
			valid_s1 <= in_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			entry_valid_s1 <= entry_valid;
			is_row_s1      <= is_row_command;
			length_s1      <= command_length;
			cand_s1        <= '{code: command_code, slot: entry_index,
				payload: payload_id, issue: issue_time};
			now_s1         <= current_time;
			last_s1        <= last_entry;
		end
	end

	// Running winner update.
	always_comb begin
		cand_key = {1'b0, cand_s1.issue} + {{(KeyWidth-LengthWidth){1'b0}}, length_s1};
		to_col   = (policy_q == POLICY_RAS_CAS) && !is_row_s1;
		row_take = entry_valid_s1 && !to_col && (!row_found_q || cand_key < row_key_q ||
			(cand_key == row_key_q && cand_s1.payload < row_rec_q.payload));
		col_take = entry_valid_s1 && to_col && (!col_found_q || cand_key < col_key_q ||
			(cand_key == col_key_q && cand_s1.payload < col_rec_q.payload));
		row_found_d = row_found_q || row_take;
		row_key_d   = row_take ? cand_key : row_key_q;
		row_rec_d   = row_take ? cand_s1 : row_rec_q;
		col_found_d = col_found_q || col_take;
		col_key_d   = col_take ? cand_key : col_key_q;
		col_rec_d   = col_take ? cand_s1 : col_rec_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_found_q <= 1'b0;
			col_found_q <= 1'b0;
		end else if (s1_fire) begin
			row_found_q <= row_found_d && !last_s1;
			col_found_q <= col_found_d && !last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			row_key_q <= row_key_d;
			row_rec_q <= row_rec_d;
			col_key_q <= col_key_d;
			col_rec_q <= col_rec_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= s1_fire && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && last_s1) begin
			policy_s2    <= (policy_q == POLICY_RAS_CAS);
			row_found_s2 <= row_found_d;
			row_rec_s2   <= row_rec_d;
			col_found_s2 <= col_found_d;
			col_rec_s2   <= col_rec_d;
			now_s2       <= now_s1;
		end
	end

	// List end: merge the class winners by raw issue time, then payload id; grant or NOP.
	always_comb begin
		have = row_found_s2;
		win  = row_rec_s2;
		if (policy_s2 && col_found_s2) begin
			if (!have || col_rec_s2.issue < win.issue ||
				(col_rec_s2.issue == win.issue && col_rec_s2.payload < win.payload)) begin
				win = col_rec_s2;
			end
			have = 1'b1;
		end
		grant_d = have && (win.issue == now_s2);
		if (grant_d) begin
			out_rec_d = win;
		end else begin
			out_rec_d = '{code: '0, slot: '0, payload: '0, issue: NopTime};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s2_go) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_go && valid_s2) begin
			grant_q   <= grant_d;
			out_rec_q <= out_rec_d;
		end
	end

	assign out_valid       = out_valid_q;
	assign grant           = grant_q;
	assign granted_command = out_rec_q.code;
	assign granted_entry   = out_rec_q.slot;
	assign granted_payload = out_rec_q.payload;
	assign granted_time    = out_rec_q.issue;

	`ORCS_ASSERT_NEXT(a_list_end_clears, clk, arst_n, s1_fire && last_s1, !row_found_q && !col_found_q)
	`ORCS_ASSERT_SAME(a_stall_holds_item, clk, arst_n, in_stall, valid_s1 && last_s1 && valid_s2)
	`ORCS_ASSERT_SAME(a_nop_fields, clk, arst_n, out_valid_q && !grant_q, out_rec_q.code == '0 && out_rec_q.slot == '0 && out_rec_q.payload == '0 && out_rec_q.issue == NopTime)

endmodule
